@@ sv/achg_pkg.sv @@
package achg_pkg;

  // Field and register widths.
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int COORD_BITS = 12;

  // Sine format: magnitude with SINE_FRAC_BITS fraction bits, 1.0 held exactly.
  localparam int SINE_FRAC_BITS = 15;
  localparam int SINE_W         = SINE_FRAC_BITS + 1;

  // Time keeping limits.
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int HALF_DAY      = 12;
  localparam int MAX_HOURS     = HOURS_PER_DAY - 1;
  localparam int MAX_MINUTES   = MIN_PER_HOUR - 1;
  localparam int MAX_SECONDS   = SEC_PER_MIN - 1;

  // Angle units. The minute hand runs in tenths of a degree, the hour hand in
  // half degrees (five tenths) and the second hand in six degree steps.
  localparam int TENTHS_TURN = 3600;
  localparam int TENTHS_QTR  = TENTHS_TURN / 4;
  localparam int HOUR_STEP   = 5;
  localparam int SEC_STEP    = 60;
  localparam int HOUR_QTR    = TENTHS_QTR / HOUR_STEP;
  localparam int SEC_QTR     = TENTHS_QTR / SEC_STEP;
  localparam int ANG_W       = $clog2(TENTHS_TURN + TENTHS_QTR);

  localparam int QADDR_W = $clog2(TENTHS_QTR + 1);
  localparam int HIDX_W  = $clog2(HOUR_QTR + 1);
  localparam int SIDX_W  = $clog2(SEC_QTR + 1);

  // Coordinate arithmetic: centre plus or minus an offset no larger than a length.
  localparam int SUM_W = CFG_W + 2;
  localparam int EXT_W = (COORD_BITS > SUM_W) ? COORD_BITS : SUM_W;

  localparam logic [63:0] PI_Q32 = 64'd13493037705;

  // Register reset values.
  localparam logic [CFG_W-1:0] CENTER_X_RST      = CFG_W'(120);
  localparam logic [CFG_W-1:0] CENTER_Y_RST      = CFG_W'(120);
  localparam logic [CFG_W-1:0] HOUR_LENGTH_RST   = CFG_W'(60);
  localparam logic [CFG_W-1:0] MINUTE_LENGTH_RST = CFG_W'(84);
  localparam logic [CFG_W-1:0] SECOND_LENGTH_RST = CFG_W'(96);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_HOUR_LENGTH   = 3'd2,
    CFG_MINUTE_LENGTH = 3'd3,
    CFG_SECOND_LENGTH = 3'd4
  } cfg_reg_e;

  // Sine or cosine of one hand: magnitude and sign.
  typedef struct packed {
    logic              neg;
    logic [SINE_W-1:0] mag;
  } trig_t;

  // An angle folded into the first quadrant.
  typedef struct packed {
    logic             neg;
    logic [ANG_W-1:0] r;
  } fold_t;

  typedef logic [TENTHS_QTR:0][SINE_W-1:0] quarter_rom_t;
  typedef logic [HOUR_QTR:0][SINE_W-1:0]   hour_rom_t;
  typedef logic [SEC_QTR:0][SINE_W-1:0]    sec_rom_t;

  // Rounded sine of r tenths of a degree, r in the first quadrant. Built from a
  // Taylor series with 31 fraction bits; only evaluated at elaboration.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    logic signed [63:0] v;
    logic               stop;
    x    = (64'(r) * PI_Q32 + 64'd1800) / 64'(TENTHS_TURN);
    x2   = (x * x) >> 32;
    sum  = signed'(x);
    term = signed'(x);
    stop = (r == 0);
    for (int k = 1; k <= 12; k++) begin
      if (!stop) begin
        t    = (64'(term) * x2) >> 30;
        t    = t / 64'((2 * k) * (2 * k + 1));
        term = signed'(t);
        if (term == 64'sd0) begin
          stop = 1'b1;
        end else if ((k & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    if (r == 0) begin
      sum = 64'sd0;
    end
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    if (sum > 64'sd2147483648) begin
      sum = 64'sd2147483648;
    end
    v = (sum + (64'sd1 <<< (30 - SINE_FRAC_BITS))) >>> (31 - SINE_FRAC_BITS);
    if (v > (64'sd1 <<< SINE_FRAC_BITS)) begin
      v = 64'sd1 <<< SINE_FRAC_BITS;
    end
    return SINE_W'(v);
  endfunction

  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    for (int i = 0; i <= TENTHS_QTR; i++) begin
      rom[i] = quarter_sine(i);
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

  function automatic hour_rom_t build_hour_rom();
    hour_rom_t rom;
    for (int i = 0; i <= HOUR_QTR; i++) begin
      rom[i] = QUARTER_ROM[i * HOUR_STEP];
    end
    return rom;
  endfunction

  function automatic sec_rom_t build_sec_rom();
    sec_rom_t rom;
    for (int i = 0; i <= SEC_QTR; i++) begin
      rom[i] = QUARTER_ROM[i * SEC_STEP];
    end
    return rom;
  endfunction

  localparam hour_rom_t HOUR_ROM = build_hour_rom();
  localparam sec_rom_t  SEC_ROM  = build_sec_rom();

  // Folds an angle below five quarters of a turn into the first quadrant.
  function automatic fold_t fold_angle(input logic [ANG_W-1:0] a,
                                       input logic [ANG_W-1:0] qtr);
    logic [ANG_W-1:0] v;
    logic [1:0]       q;
    fold_t            f;
    v = a;
    q = 2'd0;
    if (v >= {qtr[ANG_W-3:0], 2'b00}) begin
      v = v - {qtr[ANG_W-3:0], 2'b00};
    end
    for (int i = 0; i < 3; i++) begin
      if (v >= qtr) begin
        v = v - qtr;
        q = q + 2'd1;
      end
    end
    f.neg = q[1];
    f.r   = q[0] ? (qtr - v) : v;
    return f;
  endfunction

  // Clamps a coordinate into the signed output range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v);
    logic signed [EXT_W-1:0] ve;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    ve = EXT_W'(v);
    hi = EXT_W'((2 ** (COORD_BITS - 1)) - 1);
    lo = EXT_W'(-(2 ** (COORD_BITS - 1)));
    if (ve > hi) begin
      ve = hi;
    end else if (ve < lo) begin
      ve = lo;
    end
    return COORD_BITS'(ve);
  endfunction

endpackage

@@ sv/achg_in_if.sv @@
interface achg_in_if import achg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [HOUR_W-1:0] set_hours;
  logic [MIN_W-1:0]  set_minutes;
  logic [SEC_W-1:0]  set_seconds;

  modport source (
    output valid, action, set_hours, set_minutes, set_seconds,
    input  ready
  );

  modport sink (
    input  valid, action, set_hours, set_minutes, set_seconds,
    output ready
  );
endinterface

@@ sv/achg_out_if.sv @@
interface achg_out_if import achg_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [HOUR_W-1:0]            now_hours;
  logic [MIN_W-1:0]             now_minutes;
  logic [SEC_W-1:0]             now_seconds;
  logic signed [COORD_BITS-1:0] hour_tip_x;
  logic signed [COORD_BITS-1:0] hour_tip_y;
  logic signed [COORD_BITS-1:0] minute_tip_x;
  logic signed [COORD_BITS-1:0] minute_tip_y;
  logic signed [COORD_BITS-1:0] second_tip_x;
  logic signed [COORD_BITS-1:0] second_tip_y;

  modport source (
    output valid, now_hours, now_minutes, now_seconds,
           hour_tip_x, hour_tip_y, minute_tip_x, minute_tip_y,
           second_tip_x, second_tip_y,
    input  ready
  );

  modport sink (
    input  valid, now_hours, now_minutes, now_seconds,
           hour_tip_x, hour_tip_y, minute_tip_x, minute_tip_y,
           second_tip_x, second_tip_y,
    output ready
  );
endinterface

@@ sv/achg_ram.sv @@
module achg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ sv/achg_tip.sv @@
module achg_tip import achg_pkg::*; (
  input  logic [CFG_W-1:0]             center_x_i,
  input  logic [CFG_W-1:0]             center_y_i,
  input  logic [CFG_W-1:0]             length_i,
  input  trig_t                        sin_i,
  input  trig_t                        cos_i,
  output logic signed [COORD_BITS-1:0] tip_x_o,
  output logic signed [COORD_BITS-1:0] tip_y_o
);

  logic [CFG_W+SINE_W-1:0] prod_x;
  logic [CFG_W+SINE_W-1:0] prod_y;
  logic [CFG_W-1:0]        off_x;
  logic [CFG_W-1:0]        off_y;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;

  // The offset never exceeds the length, since the magnitude is at most one.
  assign prod_x = (CFG_W+SINE_W)'(length_i) * (CFG_W+SINE_W)'(sin_i.mag);
  assign prod_y = (CFG_W+SINE_W)'(length_i) * (CFG_W+SINE_W)'(cos_i.mag);
  assign off_x  = prod_x[SINE_FRAC_BITS +: CFG_W];
  assign off_y  = prod_y[SINE_FRAC_BITS +: CFG_W];

  // Screen y grows downward, so the cosine term is subtracted.
  always_comb begin
    sum_x = sin_i.neg ? (signed'(SUM_W'(center_x_i)) - signed'(SUM_W'(off_x)))
                      : (signed'(SUM_W'(center_x_i)) + signed'(SUM_W'(off_x)));
    sum_y = cos_i.neg ? (signed'(SUM_W'(center_y_i)) + signed'(SUM_W'(off_y)))
                      : (signed'(SUM_W'(center_y_i)) - signed'(SUM_W'(off_y)));
  end

  assign tip_x_o = sat_coord(sum_x);
  assign tip_y_o = sat_coord(sum_y);

endmodule

@@ sv/analog_clock_hand_generator_core.sv @@
// Analog clock hand generator.
// Keeps a 24-hour time of day and, for every input transaction, returns one
// result transaction carrying the new time and the tip coordinates of the
// hour, minute and second hands. An input transaction is either a one-second
// tick (action low) or a set-time command (action high, fields clamped).
// The user must write centre and hand lengths through the configuration port
// only while no transaction is in flight; the block does not enforce this.
// The block is a two-stage pipeline: the time update, angle folding and the
// minute-hand sine memory read happen on acceptance; the table lookups,
// multiplies and coordinate sums fill the output register when the stage
// register advances. One transaction can be accepted in every cycle while
// the receiver keeps taking results.
// After reset the minute-hand sine memory is loaded from a constant table,
// one entry a cycle until all 901 are written; the input channel is not ready
// during that time, though configuration writes are taken. The time resets to
// 00:00:00 and the registers to their default values.
// When the receiver stalls, the output register holds its result and the
// pipeline stage behind it can still take one more transaction before ready
// drops; nothing is lost or repeated.
module analog_clock_hand_generator_core import achg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  achg_in_if.sink              item_i,
  achg_out_if.source           result_o
);

  // Work carried from the acceptance stage to the coordinate stage.
  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic              hour_sin_neg;
    logic [HIDX_W-1:0] hour_sin_idx;
    logic              hour_cos_neg;
    logic [HIDX_W-1:0] hour_cos_idx;
    logic              min_sin_neg;
    logic              min_cos_neg;
    logic              sec_sin_neg;
    logic [SIDX_W-1:0] sec_sin_idx;
    logic              sec_cos_neg;
    logic [SIDX_W-1:0] sec_cos_idx;
  } stage_t;

  typedef struct packed {
    logic [HOUR_W-1:0]            hours;
    logic [MIN_W-1:0]             minutes;
    logic [SEC_W-1:0]             seconds;
    logic signed [COORD_BITS-1:0] hour_x;
    logic signed [COORD_BITS-1:0] hour_y;
    logic signed [COORD_BITS-1:0] minute_x;
    logic signed [COORD_BITS-1:0] minute_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } result_t;

  // Configuration registers.
  logic [CFG_W-1:0] center_x_q;
  logic [CFG_W-1:0] center_y_q;
  logic [CFG_W-1:0] hour_length_q;
  logic [CFG_W-1:0] minute_length_q;
  logic [CFG_W-1:0] second_length_q;

  // Time of day.
  logic [HOUR_W-1:0] hours_q, hours_d;
  logic [MIN_W-1:0]  minutes_q, minutes_d;
  logic [SEC_W-1:0]  seconds_q, seconds_d;

  // Sine memory load after reset.
  logic [QADDR_W-1:0] fill_cnt_q;
  logic               fill_done_q;

  // Pipeline.
  logic    stage_valid_q;
  stage_t  stage_q, stage_d;
  logic    out_valid_q;
  result_t out_q, out_d;

  logic accept;
  logic out_free;
  logic stage_free;
  logic stage_adv;

  logic [HOUR_W-1:0] hours_half;
  logic [ANG_W-1:0]  hour_ang;
  logic [ANG_W-1:0]  min_ang;
  logic [ANG_W-1:0]  sec_ang;
  fold_t             hour_sin_f, hour_cos_f;
  fold_t             min_sin_f, min_cos_f;
  fold_t             sec_sin_f, sec_cos_f;

  logic [SINE_W-1:0] min_sin_mag;
  logic [SINE_W-1:0] min_cos_mag;
  trig_t             hour_sin, hour_cos;
  trig_t             min_sin, min_cos;
  trig_t             sec_sin, sec_cos;

  // Handshake. The output register frees up in the cycle it is taken, so a
  // steady stream flows at one transaction a cycle while the receiver stays ready.
  assign out_free     = !out_valid_q || result_o.ready;
  assign stage_adv    = stage_valid_q && out_free;
  assign stage_free   = !stage_valid_q || out_free;
  assign item_i.ready = fill_done_q && stage_free;
  assign accept       = item_i.valid && item_i.ready;

  // Configuration writes; unknown indices are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= CENTER_X_RST;
      center_y_q      <= CENTER_Y_RST;
      hour_length_q   <= HOUR_LENGTH_RST;
      minute_length_q <= MINUTE_LENGTH_RST;
      second_length_q <= SECOND_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTER_X:      center_x_q      <= cfg_wdata_i;
        CFG_CENTER_Y:      center_y_q      <= cfg_wdata_i;
        CFG_HOUR_LENGTH:   hour_length_q   <= cfg_wdata_i;
        CFG_MINUTE_LENGTH: minute_length_q <= cfg_wdata_i;
        CFG_SECOND_LENGTH: second_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next time of day. A set-time command clamps each field to its range; a
  // tick carries seconds into minutes and minutes into hours.
  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    if (item_i.action) begin
      hours_d   = (item_i.set_hours > HOUR_W'(MAX_HOURS))
                ? HOUR_W'(MAX_HOURS) : item_i.set_hours;
      minutes_d = (item_i.set_minutes > MIN_W'(MAX_MINUTES))
                ? MIN_W'(MAX_MINUTES) : item_i.set_minutes;
      seconds_d = (item_i.set_seconds > SEC_W'(MAX_SECONDS))
                ? SEC_W'(MAX_SECONDS) : item_i.set_seconds;
    end else if (seconds_q != SEC_W'(MAX_SECONDS)) begin
      seconds_d = seconds_q + SEC_W'(1);
    end else begin
      seconds_d = '0;
      if (minutes_q != MIN_W'(MAX_MINUTES)) begin
        minutes_d = minutes_q + MIN_W'(1);
      end else begin
        minutes_d = '0;
        hours_d   = (hours_q == HOUR_W'(MAX_HOURS)) ? '0 : hours_q + HOUR_W'(1);
      end
    end
  end

  // Hand angles: hour hand in half degrees, minute hand in tenths of a
  // degree, second hand in six degree steps. The cosine is the sine a
  // quarter turn further on.
  always_comb begin
    hours_half = (hours_d >= HOUR_W'(HALF_DAY)) ? hours_d - HOUR_W'(HALF_DAY) : hours_d;
    hour_ang   = ANG_W'(hours_half) * ANG_W'(MIN_PER_HOUR) + ANG_W'(minutes_d);
    min_ang    = ANG_W'(minutes_d) * ANG_W'(SEC_PER_MIN) + ANG_W'(seconds_d);
    sec_ang    = ANG_W'(seconds_d);

    hour_sin_f = fold_angle(hour_ang, ANG_W'(HOUR_QTR));
    hour_cos_f = fold_angle(hour_ang + ANG_W'(HOUR_QTR), ANG_W'(HOUR_QTR));
    min_sin_f  = fold_angle(min_ang, ANG_W'(TENTHS_QTR));
    min_cos_f  = fold_angle(min_ang + ANG_W'(TENTHS_QTR), ANG_W'(TENTHS_QTR));
    sec_sin_f  = fold_angle(sec_ang, ANG_W'(SEC_QTR));
    sec_cos_f  = fold_angle(sec_ang + ANG_W'(SEC_QTR), ANG_W'(SEC_QTR));

    stage_d.hours        = hours_d;
    stage_d.minutes      = minutes_d;
    stage_d.seconds      = seconds_d;
    stage_d.hour_sin_neg = hour_sin_f.neg;
    stage_d.hour_sin_idx = hour_sin_f.r[HIDX_W-1:0];
    stage_d.hour_cos_neg = hour_cos_f.neg;
    stage_d.hour_cos_idx = hour_cos_f.r[HIDX_W-1:0];
    stage_d.min_sin_neg  = min_sin_f.neg;
    stage_d.min_cos_neg  = min_cos_f.neg;
    stage_d.sec_sin_neg  = sec_sin_f.neg;
    stage_d.sec_sin_idx  = sec_sin_f.r[SIDX_W-1:0];
    stage_d.sec_cos_neg  = sec_cos_f.neg;
    stage_d.sec_cos_idx  = sec_cos_f.r[SIDX_W-1:0];
  end

  // Control state: time, memory load and pipeline occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q       <= '0;
      minutes_q     <= '0;
      seconds_q     <= '0;
      fill_cnt_q    <= '0;
      fill_done_q   <= 1'b0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (!fill_done_q) begin
        if (fill_cnt_q == QADDR_W'(TENTHS_QTR)) begin
          fill_done_q <= 1'b1;
        end else begin
          fill_cnt_q <= fill_cnt_q + QADDR_W'(1);
        end
      end
      if (accept) begin
        hours_q   <= hours_d;
        minutes_q <= minutes_d;
        seconds_q <= seconds_d;
      end
      if (stage_free) begin
        stage_valid_q <= accept;
      end
      if (out_free) begin
        out_valid_q <= stage_valid_q;
      end
    end
  end

  // Payload registers. The memory read data only changes on acceptance, so it
  // stays aligned with the stage register while that stage is stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
    if (stage_adv) begin
      out_q <= out_d;
    end
  end

  // Full quadrant of sine values for the minute hand, read at the sine and
  // cosine indices at once.
  achg_ram #(
    .WIDTH (SINE_W),
    .DEPTH (TENTHS_QTR + 1)
  ) u_sine_ram (
    .clk_i     (clk_i),
    .we_i      (!fill_done_q),
    .waddr_i   (fill_cnt_q),
    .wdata_i   (QUARTER_ROM[fill_cnt_q]),
    .re_i      (accept),
    .raddr_a_i (min_sin_f.r[QADDR_W-1:0]),
    .raddr_b_i (min_cos_f.r[QADDR_W-1:0]),
    .rdata_a_o (min_sin_mag),
    .rdata_b_o (min_cos_mag)
  );

  // The hour and second hands only reach coarse angles, served by small
  // constant tables.
  always_comb begin
    hour_sin.neg = stage_q.hour_sin_neg;
    hour_sin.mag = HOUR_ROM[stage_q.hour_sin_idx];
    hour_cos.neg = stage_q.hour_cos_neg;
    hour_cos.mag = HOUR_ROM[stage_q.hour_cos_idx];
    min_sin.neg  = stage_q.min_sin_neg;
    min_sin.mag  = min_sin_mag;
    min_cos.neg  = stage_q.min_cos_neg;
    min_cos.mag  = min_cos_mag;
    sec_sin.neg  = stage_q.sec_sin_neg;
    sec_sin.mag  = SEC_ROM[stage_q.sec_sin_idx];
    sec_cos.neg  = stage_q.sec_cos_neg;
    sec_cos.mag  = SEC_ROM[stage_q.sec_cos_idx];
  end

  achg_tip u_hour_tip (
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .length_i   (hour_length_q),
    .sin_i      (hour_sin),
    .cos_i      (hour_cos),
    .tip_x_o    (out_d.hour_x),
    .tip_y_o    (out_d.hour_y)
  );

  achg_tip u_minute_tip (
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .length_i   (minute_length_q),
    .sin_i      (min_sin),
    .cos_i      (min_cos),
    .tip_x_o    (out_d.minute_x),
    .tip_y_o    (out_d.minute_y)
  );

  achg_tip u_second_tip (
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .length_i   (second_length_q),
    .sin_i      (sec_sin),
    .cos_i      (sec_cos),
    .tip_x_o    (out_d.second_x),
    .tip_y_o    (out_d.second_y)
  );

  assign out_d.hours   = stage_q.hours;
  assign out_d.minutes = stage_q.minutes;
  assign out_d.seconds = stage_q.seconds;

  assign result_o.valid        = out_valid_q;
  assign result_o.now_hours    = out_q.hours;
  assign result_o.now_minutes  = out_q.minutes;
  assign result_o.now_seconds  = out_q.seconds;
  assign result_o.hour_tip_x   = out_q.hour_x;
  assign result_o.hour_tip_y   = out_q.hour_y;
  assign result_o.minute_tip_x = out_q.minute_x;
  assign result_o.minute_tip_y = out_q.minute_y;
  assign result_o.second_tip_x = out_q.second_x;
  assign result_o.second_tip_y = out_q.second_y;

endmodule

@@ tb/tb_analog_clock_hand_generator_core.sv @@
// Self-checking testbench for the analog clock hand generator.
//
// Every input transaction is either a one-second tick or a set-time command.
// The block answers each one with exactly one result transaction: the new time
// and the tip coordinates of the hour, minute and second hands. A scoreboard
// keeps its own copy of the time of day and the configuration registers. It
// builds its own quarter-wave sine table from a fixed-point Taylor series.
// From these it works out the expected hands for every accepted input
// transaction. Accepted results are checked field by field, oldest
// expectation first.
//
// The run starts with a short directed sequence at the reset register values.
// It covers rollover of seconds, minutes and the day, clamping of
// out-of-range set values, set fields ignored during a tick, and the hands on
// quadrant boundaries. Random phases follow, each with its own register
// setting. The extremes are all zero, all ones, and a centre at the edge of
// the range with full-length hands, so that coordinates go negative or beyond
// 1023. Registers are only written once every expected result has come back.
// Writes to the unused register indexes go alongside, and they must change
// nothing.
module tb_analog_clock_hand_generator_core;
  import achg_pkg::*;

  localparam bit ACT_TICK = 1'b0;
  localparam bit ACT_SET  = 1'b1;

  localparam int REG_MAX     = (1 << CFG_W) - 1;
  localparam int QUIET_LIMIT = 5000;  // well beyond the table load after reset

  typedef bit [63:0] u64_t;

  // pi with 32 fraction bits; one tenth of a degree in radians is r*pi/1800
  localparam u64_t PI_SCALED = 64'd13493037705;

  typedef struct {
    logic              action;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } clock_cmd_t;

  typedef struct {
    logic [HOUR_W-1:0]            hh;
    logic [MIN_W-1:0]             mm;
    logic [SEC_W-1:0]             ss;
    logic signed [COORD_BITS-1:0] hx;
    logic signed [COORD_BITS-1:0] hy;
    logic signed [COORD_BITS-1:0] mx;
    logic signed [COORD_BITS-1:0] my;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
  } hands_t;

  // Time keeping, hand geometry and the queue of hands still owed by the block.
  class clock_hand_scoreboard;
    int     org_x, org_y, hour_len, min_len, sec_len;
    int     hh, mm, ss;
    int     sine_table[TENTHS_QTR + 1];
    hands_t expected_hands[$];
    int     errors;

    function new();
      u64_t   ang;
      u64_t   sq;
      u64_t   part;
      longint total;
      longint term;
      org_x    = 120;
      org_y    = 120;
      hour_len = 60;
      min_len  = 84;
      sec_len  = 96;
      hh       = 0;
      mm       = 0;
      ss       = 0;
      errors   = 0;
      // Series x - x^3/3! + x^5/5! ... with 31 fraction bits. Once a term has
      // reached zero it stays zero, so all twelve steps may simply run.
      for (int r = 0; r <= TENTHS_QTR; r++) begin
        ang   = (u64_t'(r) * PI_SCALED + u64_t'(TENTHS_TURN / 2)) / u64_t'(TENTHS_TURN);
        sq    = (ang * ang) >> 32;
        total = ang;
        term  = ang;
        for (int k = 1; k <= 12; k++) begin
          part = ((u64_t'(term) * sq) >> 30) / u64_t'((2 * k) * (2 * k + 1));
          term = part;
          if (k % 2 == 1) begin
            total = total - term;
          end else begin
            total = total + term;
          end
        end
        if (total < 0) begin
          total = 0;
        end
        if (total > (longint'(1) <<< 31)) begin
          total = longint'(1) <<< 31;
        end
        total = (total + (longint'(1) <<< (30 - SINE_FRAC_BITS))) >>> (31 - SINE_FRAC_BITS);
        if (total > (longint'(1) <<< SINE_FRAC_BITS)) begin
          total = longint'(1) <<< SINE_FRAC_BITS;
        end
        sine_table[r] = int'(total);
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_hands.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_CENTER_X:      org_x    = int'(value);
        CFG_CENTER_Y:      org_y    = int'(value);
        CFG_HOUR_LENGTH:   hour_len = int'(value);
        CFG_MINUTE_LENGTH: min_len  = int'(value);
        CFG_SECOND_LENGTH: sec_len  = int'(value);
        default: ;
      endcase
    endfunction

    // Signed sine of an angle in tenths of a degree.
    function int sine_of(int angle);
      int a, quad, r, v;
      a    = angle % TENTHS_TURN;
      quad = a / TENTHS_QTR;
      r    = a % TENTHS_QTR;
      if (quad % 2 == 1) begin
        r = TENTHS_QTR - r;
      end
      v = sine_table[r];
      return (quad >= 2) ? -v : v;
    endfunction

    // Length times sine, truncated toward zero.
    function int scale(int len, int s);
      int t;
      t = (len * ((s < 0) ? -s : s)) >>> SINE_FRAC_BITS;
      return (s < 0) ? -t : t;
    endfunction

    function logic signed [COORD_BITS-1:0] clamp_coord(int v);
      int hi, lo;
      hi = (1 << (COORD_BITS - 1)) - 1;
      lo = -(1 << (COORD_BITS - 1));
      if (v > hi) begin
        v = hi;
      end else if (v < lo) begin
        v = lo;
      end
      return COORD_BITS'(v);
    endfunction

    function void place_tip(int len, int angle,
                            output logic signed [COORD_BITS-1:0] tip_x,
                            output logic signed [COORD_BITS-1:0] tip_y);
      tip_x = clamp_coord(org_x + scale(len, sine_of(angle)));
      tip_y = clamp_coord(org_y - scale(len, sine_of(angle + TENTHS_QTR)));
    endfunction

    function void note_input(clock_cmd_t cmd);
      hands_t want;
      if (cmd.action == ACT_SET) begin
        hh = (cmd.hours > MAX_HOURS) ? MAX_HOURS : cmd.hours;
        mm = (cmd.minutes > MAX_MINUTES) ? MAX_MINUTES : cmd.minutes;
        ss = (cmd.seconds > MAX_SECONDS) ? MAX_SECONDS : cmd.seconds;
      end else begin
        ss++;
        if (ss >= SEC_PER_MIN) begin
          ss = 0;
          mm++;
        end
        if (mm >= MIN_PER_HOUR) begin
          mm = 0;
          hh++;
        end
        if (hh >= HOURS_PER_DAY) begin
          hh = 0;
        end
      end
      want.hh = HOUR_W'(hh);
      want.mm = MIN_W'(mm);
      want.ss = SEC_W'(ss);
      place_tip(hour_len, HOUR_STEP * MIN_PER_HOUR * (hh % HALF_DAY) + HOUR_STEP * mm,
                want.hx, want.hy);
      place_tip(min_len, SEC_STEP * mm + ss, want.mx, want.my);
      place_tip(sec_len, SEC_STEP * ss, want.sx, want.sy);
      expected_hands.push_back(want);
    endfunction

    task match_field(string name, logic signed [15:0] got,
                     logic signed [15:0] want);
      if (got !== want) begin
        report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
    endtask

    task check_result(hands_t got);
      hands_t want;
      if (expected_hands.size() == 0) begin
        report("result transaction with nothing outstanding");
        return;
      end
      want = expected_hands.pop_front();
      match_field("now_hours", got.hh, want.hh);
      match_field("now_minutes", got.mm, want.mm);
      match_field("now_seconds", got.ss, want.ss);
      match_field("hour_tip_x", got.hx, want.hx);
      match_field("hour_tip_y", got.hy, want.hy);
      match_field("minute_tip_x", got.mx, want.mx);
      match_field("minute_tip_y", got.my, want.my);
      match_field("second_tip_x", got.sx, want.sx);
      match_field("second_tip_y", got.sy, want.sy);
    endtask
  endclass

  bit                   clk = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  achg_in_if  item_if ();
  achg_out_if result_if ();

  clock_hand_scoreboard sb;
  clock_cmd_t           accepted_cmd;
  hands_t               observed_hands;
  int                   quiet_cycles = 0;
  int                   rx_left = 0;
  int                   rx_pick;

  analog_clock_hand_generator_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  always #5 clk = ~clk;

  // Transaction monitor. The result is checked before the input of the same
  // edge is noted, so that the order of the two never depends on the
  // simulator's scheduling.
  always @(posedge clk) begin
    if (rst_ni === 1'b1) begin
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        observed_hands.hh = result_if.now_hours;
        observed_hands.mm = result_if.now_minutes;
        observed_hands.ss = result_if.now_seconds;
        observed_hands.hx = result_if.hour_tip_x;
        observed_hands.hy = result_if.hour_tip_y;
        observed_hands.mx = result_if.minute_tip_x;
        observed_hands.my = result_if.minute_tip_y;
        observed_hands.sx = result_if.second_tip_x;
        observed_hands.sy = result_if.second_tip_y;
        sb.check_result(observed_hands);
      end
      if (item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
        accepted_cmd.action  = item_if.action;
        accepted_cmd.hours   = item_if.set_hours;
        accepted_cmd.minutes = item_if.set_minutes;
        accepted_cmd.seconds = item_if.set_seconds;
        sb.note_input(accepted_cmd);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
        (result_if.valid === 1'b1 && result_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[analog_clock_hand_generator_core] ERROR");
    $finish;
  end

  // The receiver runs its own stall pattern, independent of the sender:
  // short and long runs of ready mixed with short and occasionally long stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pick = $urandom_range(0, 9);
      if (rx_pick <= 3) begin
        result_if.ready <= 1'b1;
        rx_left <= $urandom_range(0, 19);
      end else if (rx_pick <= 6) begin
        result_if.ready <= 1'b0;
        rx_left <= $urandom_range(0, 5);
      end else if (rx_pick == 7) begin
        result_if.ready <= 1'b0;
        rx_left <= $urandom_range(9, 29);
      end else begin
        result_if.ready <= 1'b1;
        rx_left <= $urandom_range(39, 149);
      end
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Presents one transaction at the falling edge and holds it until accepted.
  // Valid stays high on return, so the caller must either issue again or open
  // a gap before anything else happens.
  task automatic issue(bit act, logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
                       logic [SEC_W-1:0] s);
    @(negedge clk);
    item_if.valid       <= 1'b1;
    item_if.action      <= act;
    item_if.set_hours   <= h;
    item_if.set_minutes <= m;
    item_if.set_seconds <= s;
    do @(posedge clk); while (item_if.ready !== 1'b1);
  endtask

  // Idle cycles on the input channel, with noise on the payload.
  task automatic sender_gap(int n);
    repeat (n) begin
      @(negedge clk);
      item_if.valid       <= 1'b0;
      item_if.action      <= 1'($urandom);
      item_if.set_hours   <= HOUR_W'($urandom);
      item_if.set_minutes <= MIN_W'($urandom);
      item_if.set_seconds <= SEC_W'($urandom);
    end
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain();
    sender_gap(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
  endtask

  // Writes all five registers, then scribbles on the unused indexes, which
  // the block must ignore.
  task automatic configure(int cx, int cy, int hl, int ml, int sl);
    write_reg(CFG_CENTER_X, CFG_W'(cx));
    write_reg(CFG_CENTER_Y, CFG_W'(cy));
    write_reg(CFG_HOUR_LENGTH, CFG_W'(hl));
    write_reg(CFG_MINUTE_LENGTH, CFG_W'(ml));
    write_reg(CFG_SECOND_LENGTH, CFG_W'(sl));
    for (int k = int'(CFG_SECOND_LENGTH) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks with random junk in the ignored fields. Set-time commands
  // are spread among them: some land just before a minute, hour or day
  // rollover so that the following ticks carry through, some are in range
  // and some are raw field values that need clamping. The sender works in
  // bursts of random length; about a third of the bursts run straight on
  // into the next with no gap.
  task automatic run_random(int count);
    int burst;
    int pick;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        issue(ACT_TICK, $urandom, $urandom, $urandom);
      end else if (pick == 7) begin
        issue(ACT_SET, $urandom, $urandom, $urandom);
      end else if (pick == 8) begin
        issue(ACT_SET, $urandom_range(0, MAX_HOURS), $urandom_range(0, MAX_MINUTES),
              $urandom_range(0, MAX_SECONDS));
      end else begin
        issue(ACT_SET, ($urandom_range(0, 2) == 0) ? MAX_HOURS : $urandom_range(0, MAX_HOURS),
              MAX_MINUTES, $urandom_range(MAX_SECONDS - 4, MAX_SECONDS));
      end
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          sender_gap($urandom_range(1, 12));
        end
      end
    end
  endtask

  initial begin
    sb                  = new();
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    item_if.valid       = 1'b0;
    item_if.action      = ACT_TICK;
    item_if.set_hours   = '0;
    item_if.set_minutes = '0;
    item_if.set_seconds = '0;
    result_if.ready     = 1'b0;
    repeat (2) @(negedge clk);
    rst_ni <= 1'b1;

    // Directed part, at the reset register values. The first tick leaves
    // midnight with every ignored set field high.
    issue(ACT_TICK, '1, '1, '1);
    // Day rollover through the last second of the day.
    issue(ACT_SET, 23, 59, 58);
    issue(ACT_TICK, 0, 0, 0);
    issue(ACT_TICK, 5, 17, 33);
    // Clamping: every field at its top code, then just past the limit.
    issue(ACT_SET, '1, '1, '1);
    issue(ACT_TICK, '1, '1, '1);
    issue(ACT_SET, HOURS_PER_DAY, MIN_PER_HOUR, SEC_PER_MIN);
    issue(ACT_SET, 0, 0, 0);
    // Noon folds onto the twelve o'clock position of the hour hand.
    issue(ACT_SET, 11, 59, 59);
    issue(ACT_TICK, 0, 0, 0);
    // Minute carry into the hour.
    issue(ACT_SET, 0, 59, 59);
    issue(ACT_TICK, 0, 0, 0);
    // Hands exactly on the quadrant boundaries.
    issue(ACT_SET, 3, 0, 15);
    issue(ACT_SET, 6, 0, 30);
    issue(ACT_SET, 9, 0, 45);
    issue(ACT_SET, 15, 45, 0);
    issue(ACT_SET, 21, 15, 45);

    run_random(300);

    // Each further phase starts from an idle block with a new register setting.
    for (int phase = 1; phase <= 7; phase++) begin
      drain();
      case (phase)
        1: configure(0, 0, 0, 0, 0);
        2: configure(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        3: configure(0, 0, REG_MAX, REG_MAX, REG_MAX);
        4: configure(REG_MAX, 0, REG_MAX, REG_MAX, REG_MAX);
        default: configure($urandom_range(0, REG_MAX), $urandom_range(0, REG_MAX),
                           $urandom_range(0, REG_MAX), $urandom_range(0, REG_MAX),
                           $urandom_range(0, REG_MAX));
      endcase
      run_random(230);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report("expected results never arrived");
    end
    if (sb.errors == 0) begin
      $display("[analog_clock_hand_generator_core] OK");
    end else begin
      $display("[analog_clock_hand_generator_core] ERROR");
    end
    $finish;
  end

endmodule
